[rtl/i2cms_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package i2cms_pkg;

  localparam int BITS_PER_BYTE = 8;
  localparam int CMD_W         = 3;
  localparam int BYTE_W        = 8;
  localparam int BIT_CNT_W     = 4;
  localparam int PHASE_W       = 2;

  localparam logic [BYTE_W-1:0] ACK_TIMEOUT_RESET = 8'd250;

  // command codes carried by a request
  localparam logic [CMD_W-1:0] CMD_NONE  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_START = 3'd1;
  localparam logic [CMD_W-1:0] CMD_STOP  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_WRITE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_WAIT  = 3'd5;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_START = 6'b000010,
    ST_STOP  = 6'b000100,
    ST_WRITE = 6'b001000,
    ST_READ  = 6'b010000,
    ST_WAIT  = 6'b100000
  } state_t;

endpackage

`default_nettype wire

[rtl/i2cms_ifs.sv]
`timescale 1ns / 1ps
`default_nettype none

// one bus slot request
interface i2cms_req_if import i2cms_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [BYTE_W-1:0] tx_byte;
  logic              send_ack;
  logic              sda_in;

  modport source (output valid, cmd, tx_byte, send_ack, sda_in, input ready);
  modport sink   (input valid, cmd, tx_byte, send_ack, sda_in, output ready);
endinterface

// one bus slot result
interface i2cms_res_if import i2cms_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              scl_level;
  logic              sda_level;
  logic              sda_drive;
  logic              busy_res;
  logic              done_res;
  logic [BYTE_W-1:0] rx_byte;
  logic              ack_timeout;

  modport source (output valid, scl_level, sda_level, sda_drive, busy_res, done_res,
                  rx_byte, ack_timeout, input ready);
  modport sink   (input valid, scl_level, sda_level, sda_drive, busy_res, done_res,
                  rx_byte, ack_timeout, output ready);
endinterface

`default_nettype wire

[rtl/i2c_master_byte_sequencer.sv]
// I2C master byte sequencer. Each request on in_ch is one bus time slot (typically
// produced by a fixed slot tick) and yields exactly one result on out_ch giving the
// SCL level, SDA level and drive enable for that slot plus busy, done, the last
// received byte and the ACK timeout flag. A command (start, stop, write byte MSB
// first, read byte with ACK/NACK, wait for ACK) is taken only when idle, and the
// accepting slot is already the first slot of its sequence: start and stop take
// 3 slots, write 24, read 19, wait ack 3 or more. An ACK wait that sees SDA high in
// ack_timeout_slots + 1 polls in a row runs a stop and sets ack_timeout. Rate: one
// request per clock; the slot update is a single pass of logic from the sequencer
// state registers into the result register, and a request is accepted whenever the
// result register is empty or being drained in the same cycle. cfg_wr_en writes
// ack_timeout_slots (reset 250); write it only while no sequence is running.
`timescale 1ns / 1ps
`default_nettype none

module i2c_master_byte_sequencer import i2cms_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_wr_en,
  input  wire logic [BYTE_W-1:0] cfg_wr_data,
  i2cms_req_if.sink              in_ch,
  i2cms_res_if.source            out_ch
);

  // config
  logic [BYTE_W-1:0]    ack_to_r;

  // sequencer state
  state_t               state_r,     state_nxt;
  logic [BIT_CNT_W-1:0] bit_count_r, bit_count_nxt;
  logic [PHASE_W-1:0]   phase_r,     phase_nxt;
  logic [BYTE_W-1:0]    shift_r,     shift_nxt;
  logic [BYTE_W-1:0]    poll_r,      poll_nxt;
  logic                 scl_r,       scl_nxt;
  logic                 sda_r,       sda_nxt;
  logic                 drive_r,     drive_nxt;
  logic                 timeout_r,   timeout_nxt;
  logic [BYTE_W-1:0]    rx_r,        rx_nxt;
  logic                 ack_sel_r,   ack_sel_nxt;

  // result register
  logic                 out_valid_r;
  logic                 busy_r,      busy_nxt;
  logic                 done_r,      done_nxt;

  logic                 in_fire;
  logic                 out_fire;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_fire    = out_valid_r && out_ch.ready;

  // one slot of the sequencer
  always_comb begin
    logic fin;
    state_nxt     = state_r;
    bit_count_nxt = bit_count_r;
    phase_nxt     = phase_r;
    shift_nxt     = shift_r;
    poll_nxt      = poll_r;
    scl_nxt       = scl_r;
    sda_nxt       = sda_r;
    drive_nxt     = drive_r;
    timeout_nxt   = timeout_r;
    rx_nxt        = rx_r;
    ack_sel_nxt   = ack_sel_r;
    busy_nxt      = 1'b0;
    done_nxt      = 1'b0;
    fin           = 1'b0;

    // command decode, idle only; unknown codes read as none
    if (state_r == ST_IDLE) begin
      unique case (in_ch.cmd)
        CMD_START: state_nxt = ST_START;
        CMD_STOP:  state_nxt = ST_STOP;
        CMD_WRITE: state_nxt = ST_WRITE;
        CMD_READ:  state_nxt = ST_READ;
        CMD_WAIT:  state_nxt = ST_WAIT;
        default:   state_nxt = ST_IDLE;
      endcase
      if (state_nxt != ST_IDLE) begin
        bit_count_nxt = '0;
        phase_nxt     = '0;
        poll_nxt      = '0;
        shift_nxt     = (state_nxt == ST_WRITE) ? in_ch.tx_byte : '0;
        if (state_nxt == ST_READ) ack_sel_nxt = in_ch.send_ack;
        if (state_nxt == ST_WAIT) timeout_nxt = 1'b0;
      end
    end

    if (state_nxt != ST_IDLE) begin
      busy_nxt = 1'b1;
      unique case (state_nxt)
        ST_START: begin
          drive_nxt = 1'b1;
          scl_nxt   = (phase_nxt != 2'd2);
          sda_nxt   = (phase_nxt == 2'd0);
          if (phase_nxt >= 2'd2) fin = 1'b1;
          else phase_nxt = phase_nxt + 2'd1;
        end
        ST_STOP: begin
          drive_nxt = 1'b1;
          scl_nxt   = (phase_nxt != 2'd0);
          sda_nxt   = (phase_nxt >= 2'd2);
          if (phase_nxt >= 2'd2) fin = 1'b1;
          else phase_nxt = phase_nxt + 2'd1;
        end
        ST_WRITE: begin
          drive_nxt = 1'b1;
          scl_nxt   = (phase_nxt == 2'd1);
          sda_nxt   = shift_nxt[BYTE_W-1];
          if (phase_nxt >= 2'd2) begin
            shift_nxt     = {shift_nxt[BYTE_W-2:0], 1'b0};
            bit_count_nxt = bit_count_nxt + 4'd1;
            phase_nxt     = '0;
            fin           = (bit_count_nxt >= BIT_CNT_W'(BITS_PER_BYTE));
          end else begin
            phase_nxt = phase_nxt + 2'd1;
          end
        end
        ST_READ: begin
          if (bit_count_nxt < BIT_CNT_W'(BITS_PER_BYTE)) begin
            drive_nxt = 1'b0;
            sda_nxt   = 1'b1;
            if (phase_nxt == 2'd0) begin
              scl_nxt   = 1'b0;
              phase_nxt = 2'd1;
            end else begin
              scl_nxt       = 1'b1;
              shift_nxt     = {shift_nxt[BYTE_W-2:0], in_ch.sda_in};
              bit_count_nxt = bit_count_nxt + 4'd1;
              phase_nxt     = '0;
            end
          end else begin
            // ACK/NACK bit
            drive_nxt = 1'b1;
            scl_nxt   = (phase_nxt == 2'd1);
            sda_nxt   = !ack_sel_nxt;
            if (phase_nxt >= 2'd2) begin
              rx_nxt = shift_nxt;
              fin    = 1'b1;
            end else begin
              phase_nxt = phase_nxt + 2'd1;
            end
          end
        end
        ST_WAIT: begin
          drive_nxt = 1'b0;
          sda_nxt   = 1'b1;
          if (phase_nxt == 2'd0) begin
            scl_nxt   = 1'b0;
            phase_nxt = 2'd1;
          end else if (phase_nxt == 2'd1) begin
            scl_nxt   = 1'b1;
            phase_nxt = 2'd2;
          end else if (!in_ch.sda_in) begin
            scl_nxt = 1'b0;
            fin     = 1'b1;
          end else begin
            scl_nxt = 1'b1;
            if (poll_nxt >= ack_to_r) begin
              // give up: stop sequence follows
              timeout_nxt = 1'b1;
              state_nxt   = ST_STOP;
              phase_nxt   = '0;
            end else begin
              poll_nxt = poll_nxt + 8'd1;
            end
          end
        end
        default: fin = 1'b1;
      endcase
      if (fin) begin
        done_nxt      = 1'b1;
        state_nxt     = ST_IDLE;
        bit_count_nxt = '0;
        phase_nxt     = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ack_to_r <= ACK_TIMEOUT_RESET;
    end else if (cfg_wr_en) begin
      ack_to_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      bit_count_r <= '0;
      phase_r     <= '0;
      shift_r     <= '0;
      poll_r      <= '0;
      scl_r       <= 1'b1;
      sda_r       <= 1'b1;
      drive_r     <= 1'b0;
      timeout_r   <= 1'b0;
      rx_r        <= '0;
      ack_sel_r   <= 1'b0;
      busy_r      <= 1'b0;
      done_r      <= 1'b0;
    end else if (in_fire) begin
      state_r     <= state_nxt;
      bit_count_r <= bit_count_nxt;
      phase_r     <= phase_nxt;
      shift_r     <= shift_nxt;
      poll_r      <= poll_nxt;
      scl_r       <= scl_nxt;
      sda_r       <= sda_nxt;
      drive_r     <= drive_nxt;
      timeout_r   <= timeout_nxt;
      rx_r        <= rx_nxt;
      ack_sel_r   <= ack_sel_nxt;
      busy_r      <= busy_nxt;
      done_r      <= done_nxt;
    end
  end

  // result register valid; a drained slot is refilled in the same cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  // line and status registers double as the result payload
  assign out_ch.valid       = out_valid_r;
  assign out_ch.scl_level   = scl_r;
  assign out_ch.sda_level   = sda_r;
  assign out_ch.sda_drive   = drive_r;
  assign out_ch.busy_res    = busy_r;
  assign out_ch.done_res    = done_r;
  assign out_ch.rx_byte     = rx_r;
  assign out_ch.ack_timeout = timeout_r;

  a_bit_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    bit_count_r <= BIT_CNT_W'(BITS_PER_BYTE))
    else $error("bit counter past one byte");

  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (bit_count_r == '0 && phase_r == '0))
    else $error("idle with stale bit counter or phase");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid_r)
    else $error("accepted request left no result");

  a_timeout_to_stop: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(timeout_r) |-> (state_r == ST_STOP && !drive_r))
    else $error("timeout flag raised outside an ACK wait");

endmodule

`default_nettype wire

[tb/i2cms_checker.sv]
`timescale 1ns / 1ps

// Watches both channels and the register port, predicts every slot result
// and compares it with what the sequencer returns.
module i2cms_checker import i2cms_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [BYTE_W-1:0] cfg_wr_data,
  i2cms_req_if              req,
  i2cms_res_if              res,
  output int                fail_cnt,
  output int                pending
);

  typedef struct packed {
    logic              scl;
    logic              sda;
    logic              drive;
    logic              busy;
    logic              done;
    logic [BYTE_W-1:0] rx;
    logic              timeout;
  } bus_slot_t;

  // expected line states, oldest first
  bus_slot_t line_state_q[$];

  logic [CMD_W-1:0]     seq_op;
  logic [BIT_CNT_W-1:0] bit_cnt;
  logic [PHASE_W-1:0]   phase;
  logic [BYTE_W-1:0]    shifter;
  logic [BYTE_W-1:0]    poll_cnt;
  logic [BYTE_W-1:0]    rx_last;
  logic [BYTE_W-1:0]    ack_limit;
  logic                 scl_q, sda_q, drive_q, timeout_q, ack_low;
  int                   slot_no;

  initial begin
    fail_cnt = 0;
    pending  = 0;
    slot_no  = 0;
  end

  task automatic report_mismatch(input string what);
    if (fail_cnt < 100) $display("%0t mismatch: %s", $time, what);
    fail_cnt++;
  endtask

  task automatic reset_state();
    ack_limit = ACK_TIMEOUT_RESET;
    seq_op    = CMD_NONE;
    bit_cnt   = '0;
    phase     = '0;
    shifter   = '0;
    poll_cnt  = '0;
    rx_last   = '0;
    ack_low   = 1'b0;
    scl_q     = 1'b1;
    sda_q     = 1'b1;
    drive_q   = 1'b0;
    timeout_q = 1'b0;
    line_state_q.delete();
  endtask

  // One bus slot: take a command if idle, then run the active sequence.
  function automatic bus_slot_t next_bus_slot(input logic [CMD_W-1:0] cmd,
                                              input logic [BYTE_W-1:0] tx,
                                              input logic send_ack,
                                              input logic sda_in);
    bus_slot_t r;
    logic      last;
    last   = 1'b0;
    r.busy = 1'b0;
    r.done = 1'b0;
    if (seq_op == CMD_NONE && cmd >= CMD_START && cmd <= CMD_WAIT) begin
      seq_op   = cmd;
      bit_cnt  = '0;
      phase    = '0;
      poll_cnt = '0;
      shifter  = (cmd == CMD_WRITE) ? tx : '0;
      if (cmd == CMD_READ) ack_low = send_ack;
      if (cmd == CMD_WAIT) timeout_q = 1'b0;
    end
    if (seq_op != CMD_NONE) begin
      r.busy = 1'b1;
      case (seq_op)
        CMD_START: begin
          {scl_q, sda_q, drive_q} = {phase != 2'd2, phase == 2'd0, 1'b1};
          last = (phase == 2'd2);
          if (!last) phase = phase + 1'b1;
        end
        CMD_STOP: begin
          {scl_q, sda_q, drive_q} = {phase != 2'd0, phase == 2'd2, 1'b1};
          last = (phase == 2'd2);
          if (!last) phase = phase + 1'b1;
        end
        CMD_WRITE: begin
          {scl_q, sda_q, drive_q} = {phase == 2'd1, shifter[BYTE_W-1], 1'b1};
          if (phase == 2'd2) begin
            shifter = shifter << 1;
            bit_cnt = bit_cnt + 1'b1;
            phase   = '0;
            last    = (bit_cnt == BIT_CNT_W'(BITS_PER_BYTE));
          end else begin
            phase = phase + 1'b1;
          end
        end
        CMD_READ: begin
          if (bit_cnt < BIT_CNT_W'(BITS_PER_BYTE)) begin
            if (phase == 2'd0) begin
              {scl_q, sda_q, drive_q} = 3'b010;
              phase = 2'd1;
            end else begin
              {scl_q, sda_q, drive_q} = 3'b110;
              shifter = {shifter[BYTE_W-2:0], sda_in};
              bit_cnt = bit_cnt + 1'b1;
              phase   = '0;
            end
          end else begin
            // ACK/NACK bit after the byte
            {scl_q, sda_q, drive_q} = {phase == 2'd1, !ack_low, 1'b1};
            if (phase == 2'd2) begin
              rx_last = shifter;
              last    = 1'b1;
            end else begin
              phase = phase + 1'b1;
            end
          end
        end
        CMD_WAIT: begin
          if (phase == 2'd0) begin
            {scl_q, sda_q, drive_q} = 3'b010;
            phase = 2'd1;
          end else if (phase == 2'd1) begin
            {scl_q, sda_q, drive_q} = 3'b110;
            phase = 2'd2;
          end else if (!sda_in) begin
            {scl_q, sda_q, drive_q} = 3'b010;
            last = 1'b1;
          end else begin
            {scl_q, sda_q, drive_q} = 3'b110;
            if (poll_cnt >= ack_limit) begin
              // give up: flag it and run a stop
              timeout_q = 1'b1;
              seq_op    = CMD_STOP;
              phase     = '0;
            end else begin
              poll_cnt = poll_cnt + 1'b1;
            end
          end
        end
        default: last = 1'b1;
      endcase
      if (last) begin
        r.done  = 1'b1;
        seq_op  = CMD_NONE;
        bit_cnt = '0;
        phase   = '0;
      end
    end
    r.scl     = scl_q;
    r.sda     = sda_q;
    r.drive   = drive_q;
    r.rx      = rx_last;
    r.timeout = timeout_q;
    return r;
  endfunction

  always @(posedge clk) begin
    bus_slot_t want;
    bus_slot_t got;
    if (!rst_n) begin
      reset_state();
    end else begin
      if (cfg_wr_en) ack_limit = cfg_wr_data;
      if (res.valid && res.ready) begin
        got = {res.scl_level, res.sda_level, res.sda_drive, res.busy_res,
               res.done_res, res.rx_byte, res.ack_timeout};
        if (line_state_q.size() == 0) begin
          report_mismatch($sformatf("result %0d with no request pending", slot_no));
        end else begin
          want = line_state_q.pop_front();
          if (got.scl !== want.scl)
            report_mismatch($sformatf("slot %0d scl_level %b, expected %b",
                                      slot_no, got.scl, want.scl));
          if (got.sda !== want.sda)
            report_mismatch($sformatf("slot %0d sda_level %b, expected %b",
                                      slot_no, got.sda, want.sda));
          if (got.drive !== want.drive)
            report_mismatch($sformatf("slot %0d sda_drive %b, expected %b",
                                      slot_no, got.drive, want.drive));
          if (got.busy !== want.busy)
            report_mismatch($sformatf("slot %0d busy %b, expected %b",
                                      slot_no, got.busy, want.busy));
          if (got.done !== want.done)
            report_mismatch($sformatf("slot %0d done %b, expected %b",
                                      slot_no, got.done, want.done));
          if (got.rx !== want.rx)
            report_mismatch($sformatf("slot %0d rx_byte %h, expected %h",
                                      slot_no, got.rx, want.rx));
          if (got.timeout !== want.timeout)
            report_mismatch($sformatf("slot %0d ack_timeout %b, expected %b",
                                      slot_no, got.timeout, want.timeout));
        end
        slot_no++;
      end
      if (req.valid && req.ready)
        line_state_q.push_back(next_bus_slot(req.cmd, req.tx_byte, req.send_ack,
                                             req.sda_in));
    end
    pending = line_state_q.size();
  end

endmodule

[tb/tb_i2c_master_byte_sequencer.sv]
`timescale 1ns / 1ps

// Stimulus and verdict for the I2C byte sequencer. Every request is one bus
// slot; the checker beside the block predicts and compares each result.
module tb_i2c_master_byte_sequencer;
  import i2cms_pkg::*;

  localparam int ITEM_TARGET  = 1950;
  localparam int HOLD_CYCLES  = 300;   // long receiver hold-off, fills the block
  localparam int STALL_LIMIT  = 3000;  // cycles with no handshake at all
  localparam int RESYNC_SLOTS = 28;    // longer than any sequence remainder

  // codes outside the command set, must act as "none"
  localparam logic [CMD_W-1:0] CMD_UNDEF_LO = 3'd6;
  localparam logic [CMD_W-1:0] CMD_UNDEF_HI = 3'd7;

  // how SDA is driven during a run of slots
  localparam int SDA_LOW  = 0;
  localparam int SDA_HIGH = 1;
  localparam int SDA_RAND = 2;

  logic              clk;
  logic              rst_n;
  logic              cfg_wr_en;
  logic [BYTE_W-1:0] cfg_wr_data;
  logic              steady;     // no idling on either side while set
  logic              hold_go;    // asks the receiver for its long hold-off
  logic [BYTE_W-1:0] ack_limit;  // current register value, shapes ACK waits
  int                slots_sent;
  int                fail_cnt;
  int                pending;

  i2cms_req_if req_ch ();
  i2cms_res_if res_ch ();

  i2c_master_byte_sequencer u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (req_ch),
    .out_ch      (res_ch)
  );

  i2cms_checker u_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .req         (req_ch),
    .res         (res_ch),
    .fail_cnt    (fail_cnt),
    .pending     (pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Receiver: random back-pressure, plus one long hold-off while the sender
  // keeps offering requests, so the result register fills and the block
  // has to stall its input.
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_go && !hold_done) begin
        hold_done = 1'b1;
        res_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      res_ch.ready <= steady || ($urandom_range(99) >= 13);
    end
  end

  // Watchdog: any cycle with a handshake on either channel restarts it.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // One request (one bus slot). Called just after a rising edge; drives at
  // the falling edge, possibly after a few random gap cycles, and returns at
  // the rising edge that accepts it.
  task automatic send_slot(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] tx,
                           input logic ack, input logic sda);
    @(negedge clk);
    while (!steady && $urandom_range(99) < 13) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.cmd      <= cmd;
    req_ch.tx_byte  <= tx;
    req_ch.send_ack <= ack;
    req_ch.sda_in   <= sda;
    do @(posedge clk); while (!req_ch.ready);
    slots_sent++;
  endtask

  // Slots while a sequence runs: random commands, which the block must ignore.
  task automatic follow(input int n, input int sda_sel);
    repeat (n)
      send_slot(CMD_W'($urandom_range(7)), BYTE_W'($urandom), 1'($urandom),
                (sda_sel == SDA_RAND) ? 1'($urandom_range(1)) : sda_sel[0]);
  endtask

  // Empty slots with SDA low: any ACK wait gets its ACK, everything else
  // runs out, so the block is idle afterwards.
  task automatic drain();
    repeat (RESYNC_SLOTS) send_slot(CMD_NONE, BYTE_W'($urandom), 1'($urandom), 1'b0);
  endtask

  // ACK wait with 'highs' polls seeing SDA high; more than the register
  // allows means timeout and the stop that follows it.
  task automatic ack_wait(input int highs);
    send_slot(CMD_WAIT, BYTE_W'($urandom), 1'($urandom), 1'($urandom));
    follow(1, SDA_RAND);
    if (highs > int'(ack_limit)) begin
      follow(int'(ack_limit) + 1, SDA_HIGH);
      follow(3, SDA_RAND);
    end else begin
      follow(highs, SDA_HIGH);
      follow(1, SDA_LOW);
    end
  endtask

  // One well-formed command with random content, exactly as long as the
  // sequence, so the next command lands on an idle block.
  task automatic run_op(input logic [CMD_W-1:0] op);
    int highs;
    case (op)
      CMD_START, CMD_STOP: begin
        send_slot(op, BYTE_W'($urandom), 1'($urandom), 1'($urandom));
        follow(2, SDA_RAND);
      end
      CMD_WRITE: begin
        send_slot(op, BYTE_W'($urandom), 1'($urandom), 1'($urandom));
        follow(3 * BITS_PER_BYTE - 1, SDA_RAND);
      end
      CMD_READ: begin
        send_slot(op, BYTE_W'($urandom), 1'($urandom), 1'($urandom));
        follow(2 * BITS_PER_BYTE + 2, SDA_RAND);
      end
      default: begin
        // timeouts only where the limit keeps them short
        if (ack_limit <= 8'd20 && $urandom_range(3) == 0)
          highs = int'(ack_limit) + 1;
        else if (ack_limit <= 8'd20 && $urandom_range(3) == 0)
          highs = int'(ack_limit);
        else
          highs = $urandom_range((ack_limit < 8'd6) ? int'(ack_limit) : 6);
        ack_wait(highs);
      end
    endcase
  endtask

  // Stray slots or a cut-off sequence, then a resync.
  task automatic noise();
    if ($urandom_range(1)) begin
      repeat ($urandom_range(1, 6))
        send_slot(CMD_W'($urandom_range(7)), BYTE_W'($urandom), 1'($urandom),
                  1'($urandom));
    end else begin
      send_slot(CMD_W'($urandom_range(CMD_START, CMD_WAIT)), BYTE_W'($urandom),
                1'($urandom), 1'($urandom));
      follow($urandom_range(1, 12), SDA_RAND);
    end
    drain();
  endtask

  task automatic random_until(input int target);
    while (slots_sent < target) begin
      if ($urandom_range(99) < 10)
        noise();
      else
        run_op(CMD_W'($urandom_range(CMD_START, CMD_WAIT)));
    end
  endtask

  // Register write: block idle and every result back first.
  task automatic set_limit(input logic [BYTE_W-1:0] v);
    drain();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    ack_limit = v;
  endtask

  initial begin
    rst_n           = 1'b0;
    cfg_wr_en       = 1'b0;
    cfg_wr_data     = '0;
    steady          = 1'b0;
    hold_go         = 1'b0;
    ack_limit       = ACK_TIMEOUT_RESET;
    slots_sent      = 0;
    req_ch.valid    = 1'b0;
    req_ch.cmd      = CMD_NONE;
    req_ch.tx_byte  = '0;
    req_ch.send_ack = 1'b0;
    req_ch.sda_in   = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset limit: directed extremes first.
    run_op(CMD_START);
    send_slot(CMD_WRITE, 8'hFF, 1'b0, 1'b1);
    follow(3 * BITS_PER_BYTE - 1, SDA_RAND);
    ack_wait(0);                            // ACK on the first poll
    send_slot(CMD_WRITE, 8'h00, 1'b1, 1'b0);
    follow(3 * BITS_PER_BYTE - 1, SDA_RAND);
    ack_wait(int'(ack_limit));              // ACK on the last poll before timeout
    send_slot(CMD_READ, 8'h00, 1'b1, 1'b1); // all ones, answered with ACK
    follow(2 * BITS_PER_BYTE + 2, SDA_HIGH);
    send_slot(CMD_READ, 8'hFF, 1'b0, 1'b0); // all zeros, answered with NACK
    follow(2 * BITS_PER_BYTE + 2, SDA_LOW);
    run_op(CMD_STOP);
    send_slot(CMD_UNDEF_LO, BYTE_W'($urandom), 1'($urandom), 1'($urandom));
    send_slot(CMD_UNDEF_HI, BYTE_W'($urandom), 1'($urandom), 1'($urandom));
    send_slot(CMD_NONE, BYTE_W'($urandom), 1'($urandom), 1'($urandom));
    random_until(650);

    // Zero limit: timeout on the first high poll.
    set_limit(8'd0);
    ack_wait(1);
    ack_wait(0);
    hold_go = 1'b1;
    random_until(1000);

    // Largest limit: one full-length timeout.
    set_limit(8'd255);
    ack_wait(256);
    random_until(1400);

    // Small limit, no idling on either side.
    steady = 1'b1;
    set_limit(8'd1);
    random_until(1700);
    steady = 1'b0;

    set_limit(BYTE_W'($urandom_range(2, 254)));
    random_until(ITEM_TARGET);

    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    if (fail_cnt == 0 && pending == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
